[hdl/can_id_mask_filter_table_assert.svh]
// assertion macros for the can id mask filter table
// used by the top level; expects signals named clock and reset in scope
`ifndef CAN_ID_MASK_FILTER_TABLE_ASSERT_SVH
`define CAN_ID_MASK_FILTER_TABLE_ASSERT_SVH

// same-cycle implication, off during reset
`define CIMFT_ASSERT_IMP(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("cimft: same-cycle check failed");

// next-cycle implication, off during reset
`define CIMFT_ASSERT_NXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("cimft: next-cycle check failed");

`endif

[hdl/cimft_pkg.sv]
// shared types and codes of the can id mask filter table
// no dependencies
package cimft_pkg;

   localparam int ID_W     = 29;
   localparam int HD_W     = 8;
   localparam int SLOT_W   = 6;
   localparam int STATUS_W = 3;
   localparam int OP_W     = 2;

   // opcodes of an input beat
   localparam logic [OP_W-1:0] OP_REG   = 2'd0;
   localparam logic [OP_W-1:0] OP_UNREG = 2'd1;
   localparam logic [OP_W-1:0] OP_MATCH = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK          = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOT_ENABLED = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_HANDLER = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_TABLE_FULL  = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND   = 3'd4;

   // one stored filter
   typedef struct packed {
      logic [ID_W-1:0] id;
      logic [ID_W-1:0] mask;
      logic [HD_W-1:0] handler;
   } entry_type;

   // one result beat
   typedef struct packed {
      logic                last;
      logic [SLOT_W-1:0]   slot;
      logic [HD_W-1:0]     hit_handler;
      logic                hit;
      logic [STATUS_W-1:0] status;
   } rsp_type;

endpackage

[hdl/cimft_entry_ram.sv]
// filter entry store: one write port, one registered read port
// depends on cimft_pkg for the entry type
module cimft_entry_ram
   import cimft_pkg::*;
#(
   parameter  int SLOTS = 10,
   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [IDX_W-1:0]      wr_addr,
   input  entry_type             wr_data,
   input  logic [IDX_W-1:0]      rd_addr,
   output entry_type             rd_data
);
   entry_type mem [SLOTS];
   entry_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/can_id_mask_filter_table.sv]
// top level of the can id mask filter table
// depends on cimft_pkg, cimft_entry_ram and can_id_mask_filter_table_assert.svh
//
// Table of SLOTS CAN acceptance filters (id, mask, handler tag) held in a
// single-port-read entry RAM, with per-slot valid bits in flip-flops that reset
// clears. A register beat writes the lowest free slot found from the valid bits
// and passes through an accept and a result step, as does any refused register
// or unregister. Unregister and match scan the RAM slot by slot (read address,
// then compare on the registered data); an unregister stops after the slot that
// hits. Every beat waits while the response register is full. A match gives one
// beat per hit in slot order with tlast on the final one, or a single no-hit
// beat. The enable register sits at byte address 0 of the csr port.
`include "can_id_mask_filter_table_assert.svh"

module can_id_mask_filter_table
   import cimft_pkg::*;
#(
   parameter int SLOTS = 10
) (
   input  logic        clock,
   input  logic        reset,
   // csr port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   // request beats; tdata: frame_id[28:0], id_mask[57:29], handler[65:58],
   // zero fill[71:66]; tuser: opcode[1:0]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,
   input  logic [1:0]  req_tuser,
   // response beats; tdata: status[2:0], hit_handler[10:3], slot[16:11],
   // zero fill[23:17]; tuser: hit
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,
   output logic        rsp_tuser,
   output logic        rsp_tlast
);
   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

   // sequencer states
   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_READ   = 2'd1;
   localparam logic [1:0] ST_TEST   = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [OP_W-1:0]  op_ff, op_in;
   logic [ID_W-1:0]  id_ff, id_in;
   logic [HD_W-1:0]  hd_ff, hd_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [SLOTS-1:0] valid_ff, valid_in;
   logic             enabled_ff;
   logic             pend_ff, pend_in;
   logic [IDX_W-1:0] pend_slot_ff, pend_slot_in;
   logic [HD_W-1:0]  pend_hd_ff, pend_hd_in;
   rsp_type          res_ff, res_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic             req_fire;
   logic             out_free;
   logic [OP_W-1:0]  req_op;
   logic [ID_W-1:0]  req_id;
   logic [ID_W-1:0]  req_mask;
   logic [HD_W-1:0]  req_hd;
   logic             free_found;
   logic [IDX_W-1:0] free_idx;
   logic             wr_en;
   entry_type        wr_data;
   entry_type        rd_data;
   logic             match_hit;
   logic             unreg_hit;
   logic             unreg_done;
   logic             csr_write;

   // request fields
   assign req_op   = req_tuser;
   assign req_id   = req_tdata[28:0];
   assign req_mask = req_tdata[57:29];
   assign req_hd   = req_tdata[65:58];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign out_free   = ~rsp_valid_ff | rsp_tready;

   // csr access
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_prdata = csr_paddr[2] ? 32'd0 : {31'd0, enabled_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= 1'b0;
      end else if (csr_write && !csr_paddr[2]) begin
         enabled_ff <= csr_pwdata[0];
      end
   end

   // lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(i);
         end
      end
   end

   // entry store
   assign wr_en = req_fire && (req_op == OP_REG) && enabled_ff && (req_hd != '0) &&
                  free_found;
   assign wr_data = '{id: req_id, mask: req_mask, handler: req_hd};

   cimft_entry_ram #(
      .SLOTS(SLOTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (free_idx),
      .wr_data (wr_data),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   // compares on the entry read back
   assign match_hit = valid_ff[idx_ff] &&
                      ((id_ff & rd_data.mask) == (rd_data.id & rd_data.mask));
   assign unreg_hit = valid_ff[idx_ff] && (rd_data.id == id_ff) &&
                      (rd_data.handler == hd_ff);
   assign unreg_done = (state_ff == ST_TEST) && (op_ff == OP_UNREG) && unreg_hit;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      id_in        = id_ff;
      hd_in        = hd_ff;
      idx_in       = idx_ff;
      valid_in     = valid_ff;
      pend_in      = pend_ff;
      pend_slot_in = pend_slot_ff;
      pend_hd_in   = pend_hd_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_in       = rsp_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_in  = req_op;
               id_in  = req_id;
               hd_in  = req_hd;
               idx_in = '0;
               res_in = '{last: 1'b1, default: '0};
               if ((req_op == OP_REG) || (req_op == OP_UNREG)) begin
                  state_in = ST_FINISH;
                  if (!enabled_ff) begin
                     res_in.status = STATUS_NOT_ENABLED;
                  end else if (req_hd == '0) begin
                     res_in.status = STATUS_BAD_HANDLER;
                  end else if (req_op == OP_UNREG) begin
                     state_in = ST_READ;
                  end else if (free_found) begin
                     valid_in[free_idx] = 1'b1;
                     res_in.slot        = SLOT_W'(free_idx);
                  end else begin
                     res_in.status = STATUS_TABLE_FULL;
                  end
               end else if (req_op == OP_MATCH) begin
                  pend_in  = 1'b0;
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            state_in = ST_TEST;
         end
         ST_TEST: begin
            if (op_ff == OP_UNREG) begin
               // first exact id and handler hit frees its slot
               if (unreg_hit) begin
                  valid_in[idx_ff] = 1'b0;
                  res_in   = '{last: 1'b1, slot: SLOT_W'(idx_ff), default: '0};
                  state_in = ST_FINISH;
               end else if (idx_ff == LAST_IDX) begin
                  res_in   = '{last: 1'b1, status: STATUS_NOT_FOUND, default: '0};
                  state_in = ST_FINISH;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_READ;
               end
            end else if (!(match_hit && pend_ff && !out_free)) begin
               // a new hit pushes out the one held back
               if (match_hit) begin
                  if (pend_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_in = '{last: 1'b0, slot: SLOT_W'(pend_slot_ff),
                                hit_handler: pend_hd_ff, hit: 1'b1,
                                status: STATUS_OK};
                  end
                  pend_in      = 1'b1;
                  pend_slot_in = idx_ff;
                  pend_hd_in   = rd_data.handler;
               end
               if (idx_ff == LAST_IDX) begin
                  // a hit in the last slot, else the held hit or a no-hit, becomes the closing beat
                  priority if (match_hit) begin
                     res_in = '{last: 1'b1, slot: SLOT_W'(idx_ff),
                                hit_handler: rd_data.handler, hit: 1'b1,
                                status: STATUS_OK};
                  end else if (pend_ff) begin
                     res_in = '{last: 1'b1, slot: SLOT_W'(pend_slot_ff),
                                hit_handler: pend_hd_ff, hit: 1'b1,
                                status: STATUS_OK};
                  end else begin
                     res_in = '{last: 1'b1, default: '0};
                  end
                  pend_in  = 1'b0;
                  state_in = ST_FINISH;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_READ;
               end
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_REG;
         idx_ff       <= '0;
         valid_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         idx_ff       <= idx_in;
         valid_ff     <= valid_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      id_ff        <= id_in;
      hd_ff        <= hd_in;
      pend_slot_ff <= pend_slot_in;
      pend_hd_ff   <= pend_hd_in;
      res_ff       <= res_in;
      rsp_ff       <= rsp_in;
   end

   // response beat
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_ff.slot, rsp_ff.hit_handler, rsp_ff.status};
   assign rsp_tuser  = rsp_ff.hit;
   assign rsp_tlast  = rsp_ff.last;

   // checks
   `CIMFT_ASSERT_IMP(a_idx_range, 1'b1, idx_ff <= LAST_IDX)
   `CIMFT_ASSERT_NXT(a_reg_sets_valid, wr_en, valid_ff[$past(free_idx)])
   `CIMFT_ASSERT_NXT(a_unreg_clears, unreg_done, !valid_ff[$past(idx_ff)])
   `CIMFT_ASSERT_IMP(a_pend_match_only, pend_ff, op_ff == OP_MATCH)
   `CIMFT_ASSERT_IMP(a_hit_is_ok, rsp_valid_ff && rsp_ff.hit, rsp_ff.status == STATUS_OK)

endmodule
